// ----- src/bsbr_pkg.sv -----
// Package for the block security bitmap range-set unit.
// Holds field widths, register and request codes, the sequencer state type
// and the word mask helper. No dependencies.
`default_nettype none

package bsbr_pkg;

   // Field widths
   localparam int DATA_W     = 32;
   localparam int CODE_W     = 4;
   localparam int BLK_W      = 12;
   localparam int IDX_W      = 6;
   localparam int CSR_W      = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int QUOT_W     = 27;           // byte value shifted right by at least 5

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE_CODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LIMIT     = 1'b1;

   // Register reset values
   localparam logic [CODE_W-1:0] CODE_RESET  = 4'd11;
   localparam logic [BLK_W-1:0]  LIMIT_RESET = 12'd2048;

   // Request codes
   localparam logic REQ_SET  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Response status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_CHECK,
      ST_WALK,
      ST_FLUSH,
      ST_DONE
   } st_type;

   // Mask of the bits a range covers inside one word. On the head word the
   // range starts at lo, on the tail word it ends at hi (inclusive).
   function automatic logic [DATA_W-1:0] word_mask(
      input logic       head,
      input logic [4:0] lo,
      input logic       tail,
      input logic [4:0] hi
   );
      logic [DATA_W-1:0] m_lo;
      logic [DATA_W-1:0] m_hi;
      m_lo = head ? ({DATA_W{1'b1}} << lo) : {DATA_W{1'b1}};
      m_hi = tail ? ({DATA_W{1'b1}} >> (5'd31 - hi)) : {DATA_W{1'b1}};
      return m_lo & m_hi;
   endfunction

endpackage

`default_nettype wire

// ----- src/bsbr_req_if.sv -----
// Request channel of the block security bitmap unit: valid/ready plus payload.
// Depends on bsbr_pkg for field widths.
`default_nettype none

interface bsbr_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [bsbr_pkg::DATA_W-1:0]  range_bytes;
   logic [bsbr_pkg::DATA_W-1:0]  start_bytes;
   logic                         non_secure;
   logic [bsbr_pkg::IDX_W-1:0]   word_index;

   modport source (
      output valid, req_type, range_bytes, start_bytes, non_secure, word_index,
      input  ready
   );
   modport sink (
      input  valid, req_type, range_bytes, start_bytes, non_secure, word_index,
      output ready
   );
endinterface

`default_nettype wire

// ----- src/bsbr_rsp_if.sv -----
// Response channel of the block security bitmap unit: valid/ready plus payload.
// Depends on bsbr_pkg for field widths.
`default_nettype none

interface bsbr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic [bsbr_pkg::DATA_W-1:0]  word_data;
   logic [bsbr_pkg::BLK_W-1:0]   end_block;

   modport source (
      output valid, status, word_data, end_block,
      input  ready
   );
   modport sink (
      input  valid, status, word_data, end_block,
      output ready
   );
endinterface

`default_nettype wire

// ----- src/bsbr_bitmap_ram.sv -----
// Bitmap word store: one write and one read port, registered read data,
// and a zeroing sweep after reset. Depends on bsbr_pkg for the word width.
`default_nettype none

module bsbr_bitmap_ram #(
   parameter int WORDS = 64,
   parameter int AW    = 6
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [AW-1:0]               rd_addr,
   output logic      [bsbr_pkg::DATA_W-1:0] rd_data,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [bsbr_pkg::DATA_W-1:0] wr_data,
   output logic                             clear_busy
);

   logic [bsbr_pkg::DATA_W-1:0] mem [WORDS];
   logic [bsbr_pkg::DATA_W-1:0] rd_data_ff;
   logic                        clr_busy_ff;
   logic                        clr_busy_in;
   logic [AW-1:0]               clr_ptr_ff;
   logic [AW-1:0]               clr_ptr_in;

   // Sweep pointer: one word zeroed per cycle until the last one
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_ptr_in  = clr_ptr_ff;
      if (clr_busy_ff) begin
         clr_ptr_in = clr_ptr_ff + AW'(1);
         if (clr_ptr_ff == AW'(WORDS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_ptr_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_ptr_ff  <= clr_ptr_in;
      end
   end

   // Write port, the sweep has priority
   always_ff @(posedge clock) begin
      if (clr_busy_ff && !reset) begin
         mem[clr_ptr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

`default_nettype wire

// ----- src/block_security_bitmap_range_set_unit.sv -----
// Top level of the block security bitmap range-set unit: request sequencer,
// range check and per-word read-modify-write walk.
// Depends on bsbr_pkg, bsbr_req_if, bsbr_rsp_if and bsbr_bitmap_ram.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid / ready      req_type, range_bytes, start_bytes,
//                                      non_secure, word_index
//   rsp_ch    out   valid / ready      status, word_data, end_block
//   csr_*     in    csr_wr_en          csr_index, csr_wr_data
//
// A read goes from idle straight to done; a set passes through calc, check,
// walk (one bitmap word per cycle, up to BITMAP_WORDS) and flush to done, or
// from check straight to done when rejected or empty. The walk is paced by the
// single read and write port of the store. After reset a zeroing sweep of the
// store runs before the first request is taken; configuration writes are
// taken throughout. A result waits in the output register while the next
// request is taken; the next result holds until that one is accepted.
`default_nettype none

module block_security_bitmap_range_set_unit #(
   parameter int BITMAP_WORDS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   bsbr_req_if.sink                             req_ch,
   bsbr_rsp_if.source                           rsp_ch,
   input  wire logic                            csr_wr_en,
   input  wire logic [bsbr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bsbr_pkg::CSR_W-1:0]      csr_wr_data
);

   localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam logic [15:0] CAP_BLOCKS = 16'(BITMAP_WORDS * 32);

   localparam int DW = bsbr_pkg::DATA_W;
   localparam int QW = bsbr_pkg::QUOT_W;
   localparam int BW = bsbr_pkg::BLK_W;
   localparam int PW = AW;

   bsbr_pkg::st_type state_ff, state_in;

   // Configuration
   logic [bsbr_pkg::CODE_W-1:0] code_ff, code_in;
   logic [BW-1:0]               limit_ff, limit_in;

   // Request capture
   logic          is_read_ff, is_read_in;
   logic          in_range_ff, in_range_in;
   logic          ns_ff, ns_in;
   logic [DW-1:0] range_ff, range_in;
   logic [DW-1:0] start_ff, start_in;

   // Range arithmetic
   logic [QW-1:0] first_ff, first_in;
   logic [QW-1:0] num_ff, num_in;
   logic          reject_ff, reject_in;
   logic [BW-1:0] last_end_ff, last_end_in;

   // Walk
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] first_word_ff, first_word_in;
   logic [PW-1:0] last_word_ff, last_word_in;
   logic [4:0]    head_off_ff, head_off_in;
   logic [4:0]    tail_off_ff, tail_off_in;
   logic          p_valid_ff, p_valid_in;
   logic [PW-1:0] p_ptr_ff, p_ptr_in;

   // Output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_status_ff, rsp_status_in;
   logic [DW-1:0] rsp_data_ff, rsp_data_in;
   logic [BW-1:0] rsp_end_ff, rsp_end_in;

   // Store ports
   logic          rd_en, wr_en, clear_busy;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [DW-1:0] rd_data, wr_data;

   // Combinational helpers
   logic          req_accept;
   logic          rsp_load;
   logic [4:0]    shift;
   logic [QW:0]   end_sum;
   logic [QW:0]   end_m1;
   logic [15:0]   lim;
   logic          range_over;
   logic          num_zero;
   logic [DW-1:0] mask;
   logic [15:0]   idx_ext;
   logic [15:0]   ptr_rd_ext;
   logic [15:0]   ptr_wr_ext;

   bsbr_bitmap_ram #(
      .WORDS (BITMAP_WORDS),
      .AW    (AW)
   ) u_ram (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .clear_busy (clear_busy)
   );

   // Range arithmetic: block = bytes >> (5 + code), limit clamped to capacity
   assign shift      = 5'(code_ff) + 5'd5;
   assign end_sum    = {1'b0, first_ff} + {1'b0, num_ff};
   assign end_m1     = end_sum - (QW + 1)'(1);
   assign lim        = (16'(limit_ff) > CAP_BLOCKS) ? CAP_BLOCKS : 16'(limit_ff);
   assign range_over = end_sum > (QW + 1)'(lim);
   assign num_zero   = (num_ff == '0);

   // Word mask for the word in the write stage of the walk
   assign mask = bsbr_pkg::word_mask(p_ptr_ff == first_word_ff, head_off_ff,
                                     p_ptr_ff == last_word_ff,  tail_off_ff);

   assign idx_ext    = 16'(req_ch.word_index);
   assign ptr_rd_ext = 16'(rd_ptr_ff);
   assign ptr_wr_ext = 16'(p_ptr_ff);

   assign req_accept = req_ch.valid && req_ch.ready;
   assign rsp_load   = (state_ff == bsbr_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsbr_pkg::ST_CLEAR: begin
            if (!clear_busy) state_in = bsbr_pkg::ST_IDLE;
         end
         bsbr_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_ch.req_type == bsbr_pkg::REQ_READ) ? bsbr_pkg::ST_DONE
                                                                  : bsbr_pkg::ST_CALC;
            end
         end
         bsbr_pkg::ST_CALC:  state_in = bsbr_pkg::ST_CHECK;
         bsbr_pkg::ST_CHECK: begin
            state_in = (range_over || num_zero) ? bsbr_pkg::ST_DONE : bsbr_pkg::ST_WALK;
         end
         bsbr_pkg::ST_WALK: begin
            if (rd_ptr_ff == last_word_ff) state_in = bsbr_pkg::ST_FLUSH;
         end
         bsbr_pkg::ST_FLUSH: state_in = bsbr_pkg::ST_DONE;
         bsbr_pkg::ST_DONE: begin
            if (rsp_load) state_in = bsbr_pkg::ST_IDLE;
         end
         default:  state_in = bsbr_pkg::ST_IDLE;
      endcase
   end

   // Store controls and request ready
   always_comb begin
      req_ch.ready = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = ptr_rd_ext[AW-1:0];
      wr_en        = p_valid_ff;
      wr_addr      = ptr_wr_ext[AW-1:0];
      wr_data      = ns_ff ? (rd_data | mask) : (rd_data & ~mask);
      case (state_ff)
         bsbr_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            rd_en        = req_ch.valid && (req_ch.req_type == bsbr_pkg::REQ_READ);
            rd_addr      = idx_ext[AW-1:0];
         end
         bsbr_pkg::ST_WALK: rd_en = 1'b1;
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      code_in       = code_ff;
      limit_in      = limit_ff;
      is_read_in    = is_read_ff;
      in_range_in   = in_range_ff;
      ns_in         = ns_ff;
      range_in      = range_ff;
      start_in      = start_ff;
      first_in      = first_ff;
      num_in        = num_ff;
      reject_in     = reject_ff;
      last_end_in   = last_end_ff;
      rd_ptr_in     = rd_ptr_ff;
      first_word_in = first_word_ff;
      last_word_in  = last_word_ff;
      head_off_in   = head_off_ff;
      tail_off_in   = tail_off_ff;
      p_valid_in    = (state_ff == bsbr_pkg::ST_WALK);
      p_ptr_in      = rd_ptr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_end_in    = rsp_end_ff;

      case (state_ff)
         bsbr_pkg::ST_IDLE: begin
            if (req_accept) begin
               is_read_in  = (req_ch.req_type == bsbr_pkg::REQ_READ);
               in_range_in = int'(req_ch.word_index) < BITMAP_WORDS;
               ns_in       = req_ch.non_secure;
               range_in    = req_ch.range_bytes;
               start_in    = req_ch.start_bytes;
               reject_in   = 1'b0;
            end
         end
         bsbr_pkg::ST_CALC: begin
            first_in = QW'(start_ff >> shift);
            num_in   = QW'(range_ff >> shift);
         end
         bsbr_pkg::ST_CHECK: begin
            reject_in     = range_over;
            if (!range_over) last_end_in = end_sum[BW-1:0];
            rd_ptr_in     = first_ff[PW+4:5];
            first_word_in = first_ff[PW+4:5];
            last_word_in  = end_m1[PW+4:5];
            head_off_in   = first_ff[4:0];
            tail_off_in   = end_m1[4:0];
         end
         bsbr_pkg::ST_WALK: rd_ptr_in = rd_ptr_ff + PW'(1);
         default: ;
      endcase

      // Result into the output register
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = reject_ff ? bsbr_pkg::STATUS_REJECT : bsbr_pkg::STATUS_OK;
         rsp_data_in   = (is_read_ff && in_range_ff) ? rd_data : '0;
         rsp_end_in    = last_end_ff;
      end

      // Register writes
      if (csr_wr_en) begin
         case (csr_index)
            bsbr_pkg::CSR_BLOCK_SIZE_CODE: code_in  = csr_wr_data[bsbr_pkg::CODE_W-1:0];
            bsbr_pkg::CSR_BLOCK_LIMIT:     limit_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsbr_pkg::ST_CLEAR;
         code_ff      <= bsbr_pkg::CODE_RESET;
         limit_ff     <= bsbr_pkg::LIMIT_RESET;
         last_end_ff  <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         limit_ff     <= limit_in;
         last_end_ff  <= last_end_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      is_read_ff    <= is_read_in;
      in_range_ff   <= in_range_in;
      ns_ff         <= ns_in;
      range_ff      <= range_in;
      start_ff      <= start_in;
      first_ff      <= first_in;
      num_ff        <= num_in;
      reject_ff     <= reject_in;
      rd_ptr_ff     <= rd_ptr_in;
      first_word_ff <= first_word_in;
      last_word_ff  <= last_word_in;
      head_off_ff   <= head_off_in;
      tail_off_ff   <= tail_off_in;
      p_ptr_ff      <= p_ptr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.word_data = rsp_data_ff;
   assign rsp_ch.end_block = rsp_end_ff;

   // No request is taken while the store is being zeroed
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_ch.ready)
      else $error("request taken during bitmap clear");

   // Walk writes never run past the last word of the range
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> (p_ptr_ff <= last_word_ff) && (p_ptr_ff >= first_word_ff))
      else $error("walk write outside range");

   // A rejected range leaves the recorded end unchanged
   a_reject_keeps_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsbr_pkg::ST_CHECK) && range_over |=> last_end_ff == $past(last_end_ff))
      else $error("rejected range changed end index");

   // Read and write of the walk never hit the same word in one cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write to same bitmap word");

endmodule

`default_nettype wire
